>>> rtl/underscore_hex_escape_decoder_assert.svh
// Assertion macros for the underscore hex escape decoder.
// They expect clk and rst in scope (rst is active high and synchronous).
`ifndef UNDERSCORE_HEX_ESCAPE_DECODER_ASSERT_SVH
`define UNDERSCORE_HEX_ESCAPE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define UHED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UHED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/uhed_pkg.sv
package uhed_pkg;

  localparam logic [7:0] ESC_CHAR = 8'h5F;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // What the front holds back from earlier bytes.
  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_ESC   = 2'd1,
    HELD_DIGIT = 2'd2
  } held_t;

  // One request's worth of output: 1 to 3 bytes, packed from index 0.
  // last marks the final byte of the group as the end of the identifier.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h41 + 8'd10;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h61 + 8'd10;
    end
    hex_value = v[3:0];
  endfunction

endpackage

>>> rtl/uhed_front.sv
module uhed_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  uhed_pkg::q_status_t q_stat,
  output logic                push,
  output uhed_pkg::cmd_t      push_cmd
);

  uhed_pkg::held_t held, held_next;
  logic [7:0]      held_digit, held_digit_next;
  logic            accept;
  logic            p_hold;
  uhed_pkg::cmd_t  cmd;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // a lone underscore that is not last starts an escape
  assign p_hold = (in_byte == uhed_pkg::ESC_CHAR) && !in_last;

  always_comb begin
    held_next       = uhed_pkg::HELD_NONE;
    held_digit_next = held_digit;
    cmd.cnt         = 2'd0;
    cmd.bytes       = '0;
    cmd.last        = in_last;
    unique case (held)
      uhed_pkg::HELD_ESC: begin
        if (uhed_pkg::is_hex(in_byte) && !in_last) begin
          held_next       = uhed_pkg::HELD_DIGIT;
          held_digit_next = in_byte;
        end else begin
          cmd.bytes[0] = uhed_pkg::ESC_CHAR;
          if (p_hold) begin
            cmd.cnt   = 2'd1;
            held_next = uhed_pkg::HELD_ESC;
          end else begin
            cmd.bytes[1] = in_byte;
            cmd.cnt      = 2'd2;
          end
        end
      end
      uhed_pkg::HELD_DIGIT: begin
        if (uhed_pkg::is_hex(in_byte)) begin
          cmd.bytes[0] = {uhed_pkg::hex_value(held_digit), uhed_pkg::hex_value(in_byte)};
          cmd.cnt      = 2'd1;
        end else begin
          cmd.bytes[0] = uhed_pkg::ESC_CHAR;
          cmd.bytes[1] = held_digit;
          if (p_hold) begin
            cmd.cnt   = 2'd2;
            held_next = uhed_pkg::HELD_ESC;
          end else begin
            cmd.bytes[2] = in_byte;
            cmd.cnt      = 2'd3;
          end
        end
      end
      default: begin
        if (p_hold) begin
          held_next = uhed_pkg::HELD_ESC;
        end else begin
          cmd.bytes[0] = in_byte;
          cmd.cnt      = 2'd1;
        end
      end
    endcase
  end

  assign push     = accept && (cmd.cnt != 2'd0);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= uhed_pkg::HELD_NONE;
    end else if (accept) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_digit <= held_digit_next;
    end
  end

endmodule

>>> rtl/uhed_queue.sv
`include "underscore_hex_escape_decoder_assert.svh"

module uhed_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  uhed_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output uhed_pkg::cmd_t      head,
  output uhed_pkg::q_status_t q_stat
);

  uhed_pkg::cmd_t                  mem [uhed_pkg::QUEUE_DEPTH];
  logic [uhed_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [uhed_pkg::QCNT_W-1:0]     count;

  assign head            = mem[rd_ptr];
  assign q_stat.full     = (count == uhed_pkg::QCNT_W'(uhed_pkg::QUEUE_DEPTH));
  assign q_stat.nonempty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `UHED_ASSERT_NOW(a_count_bound, 1'b1,
                   count <= uhed_pkg::QCNT_W'(uhed_pkg::QUEUE_DEPTH), "queue count over depth")
  `UHED_ASSERT_NOW(a_no_push_full, push, !q_stat.full, "push into full queue")
  `UHED_ASSERT_NOW(a_no_pop_empty, pop, q_stat.nonempty, "pop from empty queue")

endmodule

>>> rtl/uhed_back.sv
module uhed_back (
  input  logic                clk,
  input  logic                rst,
  input  uhed_pkg::cmd_t      head,
  input  uhed_pkg::q_status_t q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  logic [1:0] idx;
  logic       load;
  logic       final_byte;

  // output register free, or emptied this cycle
  assign load       = q_stat.nonempty && (!out_valid || !out_stall);
  assign final_byte = (idx == 2'(head.cnt - 2'd1));
  assign pop        = load && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= final_byte ? 2'd0 : idx + 2'd1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.bytes[idx];
      out_last <= head.last && final_byte;
    end
  end

endmodule

>>> rtl/underscore_hex_escape_decoder.sv
// Streaming decoder for identifiers escaped as underscore plus two hex digits.
// Raw bytes enter on in_byte with in_last on the final byte of an identifier;
// "_XY" with X and Y hex digits (either case) comes out as the single byte 0xXY,
// while an underscore or digit that does not complete an escape passes through
// unchanged, and everything held is flushed at the last byte, whose final
// result carries out_last. The front classifies one input request per cycle
// and drops a group of one to three output bytes into a four-entry queue; the
// back drains the queue one byte per cycle into a registered output. Input
// rate is one request per cycle whenever the queue has room (in_stall is the
// queue-full flag); output rate is one byte per cycle while out_stall is low,
// and since a stream never yields more bytes than it takes, a continuous
// stream is sustained at one byte per cycle when the output is not stalled.
// The first byte of a group passes through a queue entry and then the output
// register. No clearing pass is needed after reset.
module underscore_hex_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  uhed_pkg::q_status_t q_stat;
  uhed_pkg::cmd_t      push_cmd;
  uhed_pkg::cmd_t      head;
  logic                push;
  logic                pop;

  // front: escape state and request classification
  uhed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // short queue so each side stalls on its own
  uhed_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // back: serializes each group onto the output register
  uhed_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

>>> tb/sv/underscore_hex_escape_decoder_tb.sv
`timescale 1ns / 1ps

module underscore_hex_escape_decoder_tb;

  // Cycles with no request moving on either side before the run is declared hung.
  // A 62% receiver stall makes long dry spells rare; this covers them many times over.
  localparam int HANG_LIMIT = 5000;
  // Drain time after the last expected byte, as a margin.
  localparam int DRAIN_CYCLES = 16;
  // Raw bytes of random identifiers per phase; three phases give roughly 400 raw bytes.
  localparam int PHASE_BYTES = 130;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  // Raw characters waiting to be sent, and decoded bytes waiting to arrive.
  char_t raw_q[$];
  char_t decoded_q[$];

  // Percent of cycles the sender idles / the receiver stalls.
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  int mismatch_cnt = 0;
  int quiet_cycles = 0;

  // Escape state mirrored in the testbench.
  uhed_pkg::held_t esc_state = uhed_pkg::HELD_NONE;
  logic [7:0]      esc_digit = 8'h00;

  underscore_hex_escape_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] n;
    n = 8'h00;
    if (c <= 8'h39) n = c - 8'h30;
    else if (c <= 8'h46) n = c - 8'h37;   // 'A' -> 10
    else n = c - 8'h57;                   // 'a' -> 10
    return n[3:0];
  endfunction

  function automatic logic [7:0] rand_hex_char();
    logic [7:0] c;
    case ($urandom_range(2))
      0: c = 8'h30 + 8'($urandom_range(9));
      1: c = 8'h41 + 8'($urandom_range(5));
      default: c = 8'h61 + 8'($urandom_range(5));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (is_hex_char(c)) c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic expect_byte(input logic [7:0] b, input logic last);
    char_t e;
    e.b = b;
    e.last = last;
    decoded_q.push_back(e);
  endtask

  // Byte seen with nothing held: an underscore (not last) opens an escape.
  task automatic take_plain(input logic [7:0] b, input logic last);
    if (b == uhed_pkg::ESC_CHAR && !last) begin
      esc_state = uhed_pkg::HELD_ESC;
    end else begin
      esc_state = uhed_pkg::HELD_NONE;
      expect_byte(b, last);
    end
  endtask

  // Decode one accepted raw character into zero to three expected bytes.
  task automatic decode_char(input logic [7:0] b, input logic last);
    case (esc_state)
      uhed_pkg::HELD_ESC: begin
        if (is_hex_char(b) && !last) begin
          esc_digit = b;
          esc_state = uhed_pkg::HELD_DIGIT;
        end else begin
          expect_byte(uhed_pkg::ESC_CHAR, 1'b0);
          take_plain(b, last);
        end
      end
      uhed_pkg::HELD_DIGIT: begin
        if (is_hex_char(b)) begin
          expect_byte({nibble_of(esc_digit), nibble_of(b)}, last);
          esc_state = uhed_pkg::HELD_NONE;
        end else begin
          // failed escape: underscore and digit pass through as they were
          expect_byte(uhed_pkg::ESC_CHAR, 1'b0);
          expect_byte(esc_digit, 1'b0);
          take_plain(b, last);
        end
        esc_digit = 8'h00;
      end
      default: take_plain(b, last);
    endcase
    if (last) begin
      esc_state = uhed_pkg::HELD_NONE;
      esc_digit = 8'h00;
    end
  endtask

  // Build one random identifier from 1-5 tokens; returns its length.
  function automatic int push_ident(input int n_tok);
    logic [7:0] chars[$];
    char_t c;
    int k;
    for (int t = 0; t < n_tok; t++) begin
      k = $urandom_range(99);
      if (k < 45) begin
        // well-formed escape
        chars.push_back(uhed_pkg::ESC_CHAR);
        chars.push_back(rand_hex_char());
        chars.push_back(rand_hex_char());
      end else if (k < 55) begin
        // escape broken at the second digit
        chars.push_back(uhed_pkg::ESC_CHAR);
        chars.push_back(rand_hex_char());
        chars.push_back(rand_non_hex());
      end else if (k < 63) begin
        chars.push_back(uhed_pkg::ESC_CHAR);
      end else if (k < 73) begin
        chars.push_back(rand_hex_char());
      end else begin
        chars.push_back(8'($urandom_range(255)));
      end
    end
    foreach (chars[i]) begin
      c.b = chars[i];
      c.last = (i == chars.size() - 1);
      raw_q.push_back(c);
    end
    return chars.size();
  endfunction

  // Driver: predicts on each accepted request, then offers the next one.
  always @(posedge clk) begin
    char_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_char(in_byte, in_last);
      end
      if (!in_valid || !in_stall) begin
        if (raw_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = raw_q.pop_front();
          in_valid <= 1'b1;
          in_byte  <= nxt.b;
          in_last  <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall, and a field-by-field check of each accepted byte.
  always @(posedge clk) begin
    char_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected output byte %02h last %0b", $time, out_byte, out_last);
          mismatch_cnt++;
        end else begin
          e = decoded_q.pop_front();
          if (out_byte !== e.b) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, e.b, out_byte);
            mismatch_cnt++;
          end
          if (out_last !== e.last) begin
            $display("%0t: out_last expected %0b actual %0b", $time, e.last, out_last);
            mismatch_cnt++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles in which no request moves.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= HANG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d bytes still expected",
                 $time, HANG_LIMIT, decoded_q.size());
        $display("** underscore_hex_escape_decoder: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    // bit 8 marks the last character of an identifier
    static logic [8:0] directed_seq [24] = '{
      9'h05F, 9'h066, 9'h066, 9'h178,          // "_ff" then x: lowercase, max value
      9'h05F, 9'h030, 9'h130,                  // "_00" completed on the last byte
      9'h05F, 9'h141,                          // escape cut by the last byte
      9'h05F, 9'h034, 9'h167,                  // bad second digit: three bytes out
      9'h15F,                                  // lone underscore as last byte
      9'h05F, 9'h05F, 9'h034, 9'h131,          // underscore after failed escape
      9'h000, 9'h1FF,                          // raw byte extremes
      9'h05F, 9'h034, 9'h05F, 9'h037, 9'h161   // digit followed by a new escape
    };
    char_t c;
    int fill;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_gap_pct = 11; recv_stall_pct = 62; end
        1: begin send_gap_pct = 62; recv_stall_pct = 11; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      if (phase == 0) begin
        foreach (directed_seq[i]) begin
          c.b = directed_seq[i][7:0];
          c.last = directed_seq[i][8];
          raw_q.push_back(c);
        end
      end
      fill = 0;
      while (fill < PHASE_BYTES) fill += push_ident($urandom_range(1, 5));
      while (raw_q.size() > 0) @(posedge clk);
    end

    // all requests sent; wait for the pipeline and the expectation store to empty
    while (in_valid || decoded_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && decoded_q.size() == 0) begin
      $display("** underscore_hex_escape_decoder: PASSED **");
    end else begin
      $display("** underscore_hex_escape_decoder: FAILED **");
    end
    $finish;
  end

endmodule
